[design/imutg_pkg.sv]
package imutg_pkg;

  localparam int MAX_CAL_SAMPLES_DEF = 4096;
  localparam int CAL_SAMPLES_RESET   = 1000;
  localparam int CFG_W               = 13;
  localparam int BIAS_W              = 24;
  localparam int DPS_W               = 18;
  localparam int ANGLE_W             = 15;
  localparam int STEP_W              = 6;
  localparam int SQRT_STEPS          = 32;
  localparam int CORDIC_STEPS        = 26;
  localparam int CORD_W              = 36;
  localparam int Z_W                 = 28;
  localparam int ANGLE_LIMIT         = 11520;
  localparam int GYRO_SCALE          = 131;
  // divide by 131 as floor(n * ceil(2^32 / 131) / 2^32), exact for n below 2^25
  localparam int RATE_MAG_W          = 25;
  localparam int GYRO_RECIP          = 32786010;
  localparam int RECIP_SHIFT         = 32;

  typedef enum logic [1:0] {
    STAT_MEAS = 2'd0,
    STAT_CAL  = 2'd1,
    STAT_DONE = 2'd2
  } status_t;

  typedef enum logic {
    DIV_BIAS = 1'b0,
    DIV_RATE = 1'b1
  } div_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEL,
    ST_ACC,
    ST_CHK,
    ST_DIV_LD,
    ST_DIV_RUN,
    ST_DIV_ST,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQRT,
    ST_CORD_LD,
    ST_CORD,
    ST_ANG_ST,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              load_in;
    logic              cal_acc;
    logic              cal_clear;
    logic              div_load;
    logic              div_step;
    logic              div_store;
    logic              sq_a;
    logic              sq_b;
    logic              sqrt_step;
    logic              cord_load;
    logic              cord_step;
    logic              ang_store;
    logic              out_load;
    div_mode_t         mode;
    logic [1:0]        axis;
    logic              ang_sel;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic is_meas;
    logic cal_full;
    logic out_free;
  } sts_t;

  // arctangent of 2^-i in 2^-12 of 1/128 degree
  function automatic logic [24:0] atan_entry(input logic [4:0] i);
    logic [24:0] v;
    case (i)
      5'd0:    v = 25'd23592960;
      5'd1:    v = 25'd13927738;
      5'd2:    v = 25'd7359034;
      5'd3:    v = 25'd3735561;
      5'd4:    v = 25'd1875029;
      5'd5:    v = 25'd938429;
      5'd6:    v = 25'd469329;
      5'd7:    v = 25'd234679;
      5'd8:    v = 25'd117341;
      5'd9:    v = 25'd58671;
      5'd10:   v = 25'd29335;
      5'd11:   v = 25'd14668;
      5'd12:   v = 25'd7334;
      5'd13:   v = 25'd3667;
      5'd14:   v = 25'd1833;
      5'd15:   v = 25'd917;
      5'd16:   v = 25'd458;
      5'd17:   v = 25'd229;
      5'd18:   v = 25'd115;
      5'd19:   v = 25'd57;
      5'd20:   v = 25'd29;
      5'd21:   v = 25'd14;
      5'd22:   v = 25'd7;
      5'd23:   v = 25'd4;
      5'd24:   v = 25'd2;
      5'd25:   v = 25'd1;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

[design/imutg_ctrl.sv]
module imutg_ctrl #(
  parameter int DIV_STEPS = 44
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  imutg_pkg::sts_t sts,
  output imutg_pkg::cmd_t cmd
);
  import imutg_pkg::*;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic [1:0]        axis, axis_next;
  logic              ang_sel, ang_sel_next;
  div_mode_t         mode, mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      step    <= '0;
      axis    <= '0;
      ang_sel <= 1'b0;
      mode    <= DIV_BIAS;
    end else begin
      state   <= state_next;
      step    <= step_next;
      axis    <= axis_next;
      ang_sel <= ang_sel_next;
      mode    <= mode_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    step_next    = step;
    axis_next    = axis;
    ang_sel_next = ang_sel;
    mode_next    = mode;
    cmd          = '0;
    cmd.mode     = mode;
    cmd.axis     = axis;
    cmd.ang_sel  = ang_sel;
    cmd.step     = step;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_SEL;
        end
      end
      ST_SEL: begin
        axis_next = 2'd0;
        if (sts.is_meas) begin
          mode_next  = DIV_RATE;
          state_next = ST_DIV_LD;
        end else begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.cal_acc = 1'b1;
        state_next  = ST_CHK;
      end
      ST_CHK: begin
        if (sts.cal_full) begin
          mode_next  = DIV_BIAS;
          state_next = ST_DIV_LD;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_DIV_LD: begin
        cmd.div_load = 1'b1;
        step_next    = '0;
        state_next   = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        // rate divide is a single reciprocal multiply
        if (mode == DIV_RATE || step == STEP_W'(DIV_STEPS - 1)) state_next = ST_DIV_ST;
      end
      ST_DIV_ST: begin
        cmd.div_store = 1'b1;
        if (axis != 2'd2) begin
          axis_next  = axis + 1'b1;
          state_next = ST_DIV_LD;
        end else if (mode == DIV_BIAS) begin
          cmd.cal_clear = 1'b1;
          state_next    = ST_FIN;
        end else begin
          ang_sel_next = 1'b0;
          state_next   = ST_SQ_A;
        end
      end
      ST_SQ_A: begin
        cmd.sq_a   = 1'b1;
        state_next = ST_SQ_B;
      end
      ST_SQ_B: begin
        cmd.sq_b   = 1'b1;
        step_next  = '0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_next     = step + 1'b1;
        if (step == STEP_W'(SQRT_STEPS - 1)) state_next = ST_CORD_LD;
      end
      ST_CORD_LD: begin
        cmd.cord_load = 1'b1;
        step_next     = '0;
        state_next    = ST_CORD;
      end
      ST_CORD: begin
        cmd.cord_step = 1'b1;
        step_next     = step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) state_next = ST_ANG_ST;
      end
      ST_ANG_ST: begin
        cmd.ang_store = 1'b1;
        if (!ang_sel) begin
          ang_sel_next = 1'b1;
          state_next   = ST_SQ_A;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[design/imutg_dp.sv]
module imutg_dp #(
  parameter int MAX_CAL_SAMPLES = imutg_pkg::MAX_CAL_SAMPLES_DEF,
  parameter int DW              = 44
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic [imutg_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                  opcode,
  input  logic signed [15:0]                    accel_x,
  input  logic signed [15:0]                    accel_y,
  input  logic signed [15:0]                    accel_z,
  input  logic signed [15:0]                    rate_x,
  input  logic signed [15:0]                    rate_y,
  input  logic signed [15:0]                    rate_z,
  input  imutg_pkg::cmd_t                       cmd,
  output imutg_pkg::sts_t                       sts,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [1:0]                            status,
  output logic signed [15:0]                    g_x,
  output logic signed [15:0]                    g_y,
  output logic signed [15:0]                    g_z,
  output logic signed [imutg_pkg::DPS_W-1:0]    dps_x,
  output logic signed [imutg_pkg::DPS_W-1:0]    dps_y,
  output logic signed [imutg_pkg::DPS_W-1:0]    dps_z,
  output logic signed [imutg_pkg::ANGLE_W-1:0]  pitch,
  output logic signed [imutg_pkg::ANGLE_W-1:0]  roll
);
  import imutg_pkg::*;

  localparam int CW  = $clog2(MAX_CAL_SAMPLES + 1);
  localparam int SW  = 16 + $clog2(MAX_CAL_SAMPLES);
  localparam int TW  = (CW > CFG_W) ? CW : CFG_W;
  localparam int DVW = (CW > 8) ? CW : 8;

  logic [CFG_W-1:0] cal_samples;
  logic             op;
  logic signed [15:0] acc [3];
  logic signed [15:0] rte [3];
  logic signed [SW-1:0] sums [3];
  logic [CW-1:0]        count;
  logic signed [BIAS_W-1:0] bias [3];
  logic signed [DPS_W-1:0]  dps_r [3];
  logic signed [ANGLE_W-1:0] pitch_r, roll_r;
  status_t stat;

  // divider
  logic [DW-1:0]  dq;
  logic [DVW-1:0] drem, dvs;
  logic           dneg;
  logic signed [DW-1:0] dvd;
  logic [DVW:0]   dtrial, ddiff;
  logic signed [DW-1:0] qs;
  logic [2*RATE_MAG_W-1:0] rprod;

  // square root and cordic
  logic [31:0] sqa, srad, sroot;
  logic [33:0] srem;
  logic [63:0] sn;
  logic [5:0]  sidx;
  logic [35:0] st, str;
  logic signed [CORD_W-1:0] cx, cy, cdx, cdy;
  logic signed [Z_W-1:0]    cz, zabs;
  logic [Z_W-1:0]           zatan;
  logic [15:0]              mag;
  logic signed [ANGLE_W-1:0] ang;
  logic signed [15:0] num, o1, o2;
  logic [TW-1:0] tgt;

  // calibration length clamped to one..MAX_CAL_SAMPLES
  always_comb begin
    if (cal_samples == '0) tgt = TW'(1);
    else if (TW'(cal_samples) > TW'(MAX_CAL_SAMPLES)) tgt = TW'(MAX_CAL_SAMPLES);
    else tgt = TW'(cal_samples);
  end

  assign sts.is_meas  = op;
  assign sts.cal_full = (TW'(count) >= tgt);
  assign sts.out_free = !out_valid || !out_stall;

  always_comb begin
    if (cmd.ang_sel) begin
      num = acc[1]; o1 = acc[0];
    end else begin
      num = acc[0]; o1 = acc[1];
    end
    o2 = acc[2];
  end

  always_comb begin
    if (cmd.mode == DIV_BIAS) dvd = DW'(sums[cmd.axis]) <<< 8;
    else dvd = (DW'(rte[cmd.axis]) <<< 8) - DW'(bias[cmd.axis]);
    dtrial = {drem, dq[DW-1]};
    ddiff  = dtrial - {1'b0, dvs};
    qs     = dneg ? -signed'(dq) : signed'(dq);
    // rate magnitude stays below 2^25
    rprod  = dq[RATE_MAG_W-1:0] * RATE_MAG_W'(GYRO_RECIP);
  end

  always_comb begin
    sn   = {srad, 32'd0};
    sidx = 6'(63 - 2 * int'(cmd.step));
    st   = {srem, sn[sidx -: 2]};
    str  = {2'b00, sroot, 2'b01};
    cdx  = cy >>> cmd.step[4:0];
    cdy  = cx >>> cmd.step[4:0];
    zatan = Z_W'(atan_entry(cmd.step[4:0]));
    zabs = cz[Z_W-1] ? -cz : cz;
    mag  = 16'((zabs + Z_W'(2048)) >>> 12);
    if (mag > 16'(ANGLE_LIMIT)) mag = 16'(ANGLE_LIMIT);
    if (num == 16'sd0) ang = '0;
    else if (srad == '0) ang = num[15] ? -ANGLE_W'(ANGLE_LIMIT) : ANGLE_W'(ANGLE_LIMIT);
    else ang = cz[Z_W-1] ? -signed'(ANGLE_W'(mag)) : signed'(ANGLE_W'(mag));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_samples <= CFG_W'(CAL_SAMPLES_RESET);
      count       <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sums[i] <= '0;
        bias[i] <= '0;
      end
    end else begin
      if (cfg_valid) cal_samples <= cfg_data;
      if (cmd.cal_acc) begin
        for (int i = 0; i < 3; i++) sums[i] <= sums[i] + SW'(rte[i]);
        count <= count + 1'b1;
      end
      if (cmd.cal_clear) begin
        for (int i = 0; i < 3; i++) sums[i] <= '0;
        count <= '0;
      end
      if (cmd.div_store && cmd.mode == DIV_BIAS) bias[cmd.axis] <= qs[BIAS_W-1:0];
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op     <= opcode;
      acc[0] <= accel_x; acc[1] <= accel_y; acc[2] <= accel_z;
      rte[0] <= rate_x;  rte[1] <= rate_y;  rte[2] <= rate_z;
      stat   <= opcode ? STAT_MEAS : STAT_CAL;
      for (int i = 0; i < 3; i++) dps_r[i] <= '0;
      pitch_r <= '0;
      roll_r  <= '0;
    end
    if (cmd.cal_clear) stat <= STAT_DONE;
    if (cmd.div_load) begin
      dneg <= dvd[DW-1];
      dq   <= dvd[DW-1] ? DW'(-dvd) : DW'(dvd);
      drem <= '0;
      dvs  <= DVW'(count);
    end
    if (cmd.div_step) begin
      if (cmd.mode == DIV_RATE) begin
        dq <= DW'(rprod >> RECIP_SHIFT);
      end else if (!ddiff[DVW]) begin
        drem <= ddiff[DVW-1:0];
        dq   <= {dq[DW-2:0], 1'b1};
      end else begin
        drem <= dtrial[DVW-1:0];
        dq   <= {dq[DW-2:0], 1'b0};
      end
    end
    if (cmd.div_store && cmd.mode == DIV_RATE) dps_r[cmd.axis] <= qs[DPS_W-1:0];
    if (cmd.sq_a) sqa <= 32'(o1 * o1);
    if (cmd.sq_b) begin
      srad  <= sqa + 32'(o2 * o2);
      srem  <= '0;
      sroot <= '0;
    end
    if (cmd.sqrt_step) begin
      if (st >= str) begin
        srem  <= 34'(st - str);
        sroot <= {sroot[30:0], 1'b1};
      end else begin
        srem  <= st[33:0];
        sroot <= {sroot[30:0], 1'b0};
      end
    end
    if (cmd.cord_load) begin
      cx <= signed'(CORD_W'(sroot));
      cy <= CORD_W'(num) <<< 16;
      cz <= '0;
    end
    if (cmd.cord_step) begin
      if (!cy[CORD_W-1]) begin
        cx <= cx + cdx; cy <= cy - cdy; cz <= cz + signed'(zatan);
      end else begin
        cx <= cx - cdx; cy <= cy + cdy; cz <= cz - signed'(zatan);
      end
    end
    if (cmd.ang_store) begin
      if (cmd.ang_sel) roll_r <= ang;
      else pitch_r <= ang;
    end
    if (cmd.out_load) begin
      status <= stat;
      g_x    <= op ? acc[0] : 16'sd0;
      g_y    <= op ? acc[1] : 16'sd0;
      g_z    <= op ? acc[2] : 16'sd0;
      dps_x  <= dps_r[0];
      dps_y  <= dps_r[1];
      dps_z  <= dps_r[2];
      pitch  <= pitch_r;
      roll   <= roll_r;
    end
  end

endmodule

[design/imu_tilt_and_gyro_conditioner.sv]
// imu tilt and gyro conditioner
// input channel: in_valid / in_stall, one six-axis sample a beat, opcode 0 for a
//   calibration sample, 1 for a measurement sample
// output channel: out_valid / out_stall, one result beat per input beat, in order
// config channel: cfg_valid / cfg_ready, cfg_data is the calibration length;
//   cfg_ready is always high, write only while the block is idle
// one sample at a time; in_stall is high from acceptance until the result has
//   moved into the output register, the next beat is taken in the cycle after that
// calibration sample: accumulated into the sums and checked against the length;
//   when it closes the calibration, three passes through the restoring divider
//   by the sample count follow before the result is valid
// measurement sample: the three rates first (divide by 131 as a reciprocal
//   multiply), then pitch and roll (square, 32-step square root, 26-step
//   cordic)
// reset: calibration length back to 1000, sums, count and bias cleared, no
//   result pending
// a stalled output keeps its beat; the finished result then waits inside the
//   block and no new sample is taken until the output register frees up
module imu_tilt_and_gyro_conditioner #(
  parameter int MAX_CAL_SAMPLES = imutg_pkg::MAX_CAL_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [imutg_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  opcode,
  input  logic signed [15:0]                    accel_x,
  input  logic signed [15:0]                    accel_y,
  input  logic signed [15:0]                    accel_z,
  input  logic signed [15:0]                    rate_x,
  input  logic signed [15:0]                    rate_y,
  input  logic signed [15:0]                    rate_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            status,
  output logic signed [15:0]                    g_x,
  output logic signed [15:0]                    g_y,
  output logic signed [15:0]                    g_z,
  output logic signed [imutg_pkg::DPS_W-1:0]    dps_x,
  output logic signed [imutg_pkg::DPS_W-1:0]    dps_y,
  output logic signed [imutg_pkg::DPS_W-1:0]    dps_z,
  output logic signed [imutg_pkg::ANGLE_W-1:0]  pitch,
  output logic signed [imutg_pkg::ANGLE_W-1:0]  roll
);
  import imutg_pkg::*;

  // sums carry 16 + log2(max) bits, scaled by 256 for the bias divide;
  // at least 26 bits so the rate numerator fits
  localparam int SUM_W = 16 + $clog2(MAX_CAL_SAMPLES);
  localparam int DW    = (SUM_W + 8 > 26) ? SUM_W + 8 : 26;

  cmd_t cmd;
  sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  imutg_ctrl #(
    .DIV_STEPS(DW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  imutg_dp #(
    .MAX_CAL_SAMPLES(MAX_CAL_SAMPLES),
    .DW             (DW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .opcode    (opcode),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .rate_x    (rate_x),
    .rate_y    (rate_y),
    .rate_z    (rate_z),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .g_x       (g_x),
    .g_y       (g_y),
    .g_z       (g_z),
    .dps_x     (dps_x),
    .dps_y     (dps_y),
    .dps_z     (dps_z),
    .pitch     (pitch),
    .roll      (roll)
  );

endmodule

[design/imutg_chk.sv]
module imutg_chk (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [1:0]               status,
  input logic signed [15:0]       g_x,
  input logic signed [14:0]       pitch
);
  import imutg_pkg::*;

  // a pending result is not dropped while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  // one sample at a time: stall rises right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second sample taken while busy");

  // no result directly after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // calibration results carry a zero payload; g_x and pitch are checked
  a_cal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_CAL || status == STAT_DONE) |-> g_x == 16'sd0 && pitch == 15'sd0)
    else $error("calibration result with payload");

endmodule

bind imu_tilt_and_gyro_conditioner imutg_chk u_chk (.*);
